// ===== sv/dcsm_pkg.sv =====
`timescale 1ns / 1ps

package dcsm_pkg;

  // Field widths fixed by the item format
  localparam int SCORE_W   = 16;
  localparam int CENTER_W  = 18;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 16;

  // Default counter width for the tick timers
  localparam int COUNT_BITS_DEF = 16;

  // Smoothing sum 3*avg + 2*score + 2 fits in 19 bits
  localparam int SUM_W = 19;

  // Divide by 5 as multiply by reciprocal: exact for any sum below 2**22
  localparam int                DIV5_SHIFT = 22;
  localparam int                DIV5_W     = 20;
  localparam logic [DIV5_W-1:0] DIV5_MUL   = 20'd838861;
  localparam int                PROD_W     = SUM_W + DIV5_W;

  // Register reset values
  localparam logic [CFG_W-1:0] YELLOW_RST      = 16'd32768;
  localparam logic [CFG_W-1:0] RED_RST         = 16'd52429;
  localparam logic [CFG_W-1:0] HOLD_RST        = 16'd36;
  localparam logic [CFG_W-1:0] INVESTIGATE_RST = 16'd300;
  localparam logic [CFG_W-1:0] COOLDOWN_RST    = 16'd180;

  typedef enum logic [1:0] {
    ST_SEARCHING = 2'd0,
    ST_DETECTING = 2'd1,
    ST_DETECTED  = 2'd2
  } det_state_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_YELLOW      = 3'd0,
    REG_RED         = 3'd1,
    REG_HOLD        = 3'd2,
    REG_INVESTIGATE = 3'd3,
    REG_COOLDOWN    = 3'd4
  } cfg_reg_t;

  localparam logic ITEM_TICK   = 1'b0;
  localparam logic ITEM_SIGNAL = 1'b1;

  typedef struct packed {
    logic [CFG_W-1:0] yellow;
    logic [CFG_W-1:0] red;
    logic [CFG_W-1:0] hold;
    logic [CFG_W-1:0] investigate;
    logic [CFG_W-1:0] cooldown;
  } cfg_t;

  // Tracker state apart from the tick timers
  typedef struct packed {
    det_state_t         state;
    logic [SCORE_W-1:0] avg;
    logic               reached_red;
    logic [SCORE_W-1:0] x;
    logic [SCORE_W-1:0] y;
    logic [SCORE_W-1:0] fill;
  } trk_t;

  // Negative center goes to 0, above unity goes to full scale
  function automatic logic [SCORE_W-1:0] clamp_center(input logic signed [CENTER_W-1:0] v);
    logic [SCORE_W-1:0] res;
    if (v[CENTER_W-1]) begin
      res = '0;
    end else if (v[CENTER_W-2:SCORE_W] != '0) begin
      res = '1;
    end else begin
      res = v[SCORE_W-1:0];
    end
    return res;
  endfunction

  // (a + b + 1) >> 1, half rounds up
  function automatic logic [SCORE_W-1:0] half_avg(input logic [SCORE_W-1:0] a,
                                                  input logic [SCORE_W-1:0] b);
    logic [SCORE_W:0] s;
    s = {1'b0, a} + {1'b0, b} + (SCORE_W+1)'(1);
    return s[SCORE_W:1];
  endfunction

endpackage

// ===== sv/dcsm_in_if.sv =====
`timescale 1ns / 1ps

interface dcsm_in_if;
  import dcsm_pkg::*;

  logic                       valid;
  logic                       ready;
  logic                       kind;
  logic [SCORE_W-1:0]         signal_score;
  logic signed [CENTER_W-1:0] center_x;
  logic signed [CENTER_W-1:0] center_y;
  logic [SCORE_W-1:0]         fill;

  modport source (output valid, kind, signal_score, center_x, center_y, fill, input ready);
  modport sink   (input valid, kind, signal_score, center_x, center_y, fill, output ready);
endinterface

// ===== sv/dcsm_out_if.sv =====
`timescale 1ns / 1ps

interface dcsm_out_if;
  import dcsm_pkg::*;

  logic               valid;
  logic               ready;
  logic [1:0]         det_state;
  logic [SCORE_W-1:0] smoothed_score;
  logic [SCORE_W-1:0] target_x;
  logic [SCORE_W-1:0] target_y;
  logic [SCORE_W-1:0] target_fill;

  modport source (output valid, det_state, smoothed_score, target_x, target_y, target_fill,
                  input ready);
  modport sink   (input valid, det_state, smoothed_score, target_x, target_y, target_fill,
                  output ready);
endinterface

// ===== sv/dcsm_cfg_if.sv =====
`timescale 1ns / 1ps

interface dcsm_cfg_if;
  import dcsm_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== sv/detection_confidence_state_machine_top.sv =====
`timescale 1ns / 1ps

// Detection confidence tracker (searching / detecting / detected).
// Input channel in_ch: one word per item. kind 0 is a tick that advances the
// hold, detecting and cooldown timers; kind 1 is a signal sample that updates
// the smoothed score, the stored target and the tracker state.
// Result channel out_ch: exactly one word per input word, in order, holding
// the tracker state, smoothed score and target after that item.
// Config channel cfg_ch: register writes, always ready; index 0 yellow,
// 1 red, 2 hold, 3 investigate, 4 cooldown; other indexes are ignored.
// Write only while no item is in flight.
// Throughput is one word per cycle unless the receiver stalls; a word goes
// through the input register, then the state update lands in the state and
// result registers. The tracker state feeds back through combinational dcsm_step.
// When the receiver stalls, the result register holds and the input
// register fills, then in_ch.ready drops; nothing is lost or repeated.
// Synchronous reset puts the tracker in searching with all timers, the
// score and the target at zero and the registers at their defaults.

module detection_confidence_state_machine_top
  import dcsm_pkg::*;
#(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input logic        clk,
  input logic        rst_n,
  dcsm_in_if.sink    in_ch,
  dcsm_out_if.source out_ch,
  dcsm_cfg_if.sink   cfg_ch
);

  // Input stage
  logic                       s1_v_r;
  logic                       s1_kind_r;
  logic [SCORE_W-1:0]         s1_score_r;
  logic signed [CENTER_W-1:0] s1_cx_r;
  logic signed [CENTER_W-1:0] s1_cy_r;
  logic [SCORE_W-1:0]         s1_fill_r;

  // Tracker state
  trk_t                  trk_r,  trk_nxt;
  logic [COUNT_BITS-1:0] low_r,  low_nxt;
  logic [COUNT_BITS-1:0] det_r,  det_nxt;
  logic [COUNT_BITS-1:0] cool_r, cool_nxt;
  cfg_t                  cfg_r;

  // Result stage
  logic               out_v_r, out_v_nxt;
  logic [1:0]         out_state_r;
  logic [SCORE_W-1:0] out_score_r;
  logic [SCORE_W-1:0] out_x_r;
  logic [SCORE_W-1:0] out_y_r;
  logic [SCORE_W-1:0] out_fill_r;

  logic in_acc;
  logic adv;

  assign adv         = s1_v_r && (!out_v_r || out_ch.ready);
  assign in_ch.ready = !s1_v_r || adv;
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign out_v_nxt   = adv || (out_v_r && !out_ch.ready);
  assign cfg_ch.ready = 1'b1;

  dcsm_step #(
    .COUNT_BITS (COUNT_BITS)
  ) u_step (
    .cur          (trk_r),
    .low_cnt      (low_r),
    .det_cnt      (det_r),
    .cool_cnt     (cool_r),
    .cfg          (cfg_r),
    .kind         (s1_kind_r),
    .signal_score (s1_score_r),
    .center_x     (s1_cx_r),
    .center_y     (s1_cy_r),
    .fill         (s1_fill_r),
    .nxt          (trk_nxt),
    .low_nxt      (low_nxt),
    .det_nxt      (det_nxt),
    .cool_nxt     (cool_nxt)
  );

  // Control, tracker state and registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
      trk_r   <= '{state: ST_SEARCHING, avg: '0, reached_red: 1'b0, x: '0, y: '0, fill: '0};
      low_r   <= '0;
      det_r   <= '0;
      cool_r  <= '0;
      cfg_r   <= '{yellow: YELLOW_RST, red: RED_RST, hold: HOLD_RST,
                   investigate: INVESTIGATE_RST, cooldown: COOLDOWN_RST};
    end else begin
      if (in_acc) begin
        s1_v_r <= 1'b1;
      end else if (adv) begin
        s1_v_r <= 1'b0;
      end
      out_v_r <= out_v_nxt;
      if (adv) begin
        trk_r  <= trk_nxt;
        low_r  <= low_nxt;
        det_r  <= det_nxt;
        cool_r <= cool_nxt;
      end
      if (cfg_ch.valid) begin
        case (cfg_reg_t'(cfg_ch.index))
          REG_YELLOW:      cfg_r.yellow      <= cfg_ch.data;
          REG_RED:         cfg_r.red         <= cfg_ch.data;
          REG_HOLD:        cfg_r.hold        <= cfg_ch.data;
          REG_INVESTIGATE: cfg_r.investigate <= cfg_ch.data;
          REG_COOLDOWN:    cfg_r.cooldown    <= cfg_ch.data;
          default: ;
        endcase
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_kind_r  <= in_ch.kind;
      s1_score_r <= in_ch.signal_score;
      s1_cx_r    <= in_ch.center_x;
      s1_cy_r    <= in_ch.center_y;
      s1_fill_r  <= in_ch.fill;
    end
    if (adv) begin
      out_state_r <= trk_nxt.state;
      out_score_r <= trk_nxt.avg;
      out_x_r     <= trk_nxt.x;
      out_y_r     <= trk_nxt.y;
      out_fill_r  <= trk_nxt.fill;
    end
  end

  assign out_ch.valid          = out_v_r;
  assign out_ch.det_state      = out_state_r;
  assign out_ch.smoothed_score = out_score_r;
  assign out_ch.target_x       = out_x_r;
  assign out_ch.target_y       = out_y_r;
  assign out_ch.target_fill    = out_fill_r;

endmodule

// ===== sv/dcsm_step.sv =====
`timescale 1ns / 1ps

module dcsm_step
  import dcsm_pkg::*;
#(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  trk_t                       cur,
  input  logic [COUNT_BITS-1:0]      low_cnt,
  input  logic [COUNT_BITS-1:0]      det_cnt,
  input  logic [COUNT_BITS-1:0]      cool_cnt,
  input  cfg_t                       cfg,
  input  logic                       kind,
  input  logic [SCORE_W-1:0]         signal_score,
  input  logic signed [CENTER_W-1:0] center_x,
  input  logic signed [CENTER_W-1:0] center_y,
  input  logic [SCORE_W-1:0]         fill,
  output trk_t                       nxt,
  output logic [COUNT_BITS-1:0]      low_nxt,
  output logic [COUNT_BITS-1:0]      det_nxt,
  output logic [COUNT_BITS-1:0]      cool_nxt
);

  // Compare width covering both counters and 16-bit registers
  localparam int CMP_W = (COUNT_BITS > CFG_W) ? COUNT_BITS : CFG_W;

  logic [SUM_W-1:0]      sum;
  logic [PROD_W-1:0]     prod;
  logic [SCORE_W-1:0]    avg_new;
  logic                  hit;
  logic [CFG_W-1:0]      red_eff;
  logic [COUNT_BITS-1:0] low_sig;
  logic                  cooling;
  logic                  expired;
  logic                  drop;
  det_state_t            st_next;
  logic [CMP_W-1:0]      cnt_max_ext;
  logic [CMP_W-1:0]      cd_ext;
  logic [COUNT_BITS-1:0] cd_load;

  // Smoothed score: (3*avg + 2*score + 2) / 5
  assign sum     = SUM_W'(cur.avg) * SUM_W'(3) + SUM_W'(signal_score) * SUM_W'(2) + SUM_W'(2);
  assign prod    = PROD_W'(sum) * PROD_W'(DIV5_MUL);
  assign avg_new = prod[DIV5_SHIFT +: SCORE_W];

  // Thresholds and timeout checks
  assign hit     = signal_score >= cfg.yellow;
  assign red_eff = (cfg.red > cfg.yellow) ? cfg.red : cfg.yellow;
  assign low_sig = hit ? '0 : low_cnt;
  assign cooling = cool_cnt != '0;
  assign expired = (cur.state == ST_DETECTING) && (CMP_W'(det_cnt) > CMP_W'(cfg.investigate));
  assign drop    = (CMP_W'(low_sig) > CMP_W'(cfg.hold)) || cooling || expired;

  // Cooldown load saturated to the counter range
  assign cnt_max_ext = CMP_W'({COUNT_BITS{1'b1}});
  assign cd_ext      = CMP_W'(cfg.cooldown);
  assign cd_load     = (cd_ext > cnt_max_ext) ? {COUNT_BITS{1'b1}} : cd_ext[COUNT_BITS-1:0];

  // Next tracker state
  always_comb begin
    if (avg_new >= red_eff) begin
      st_next = ST_DETECTED;
    end else if ((avg_new >= cfg.yellow) && !cooling && !expired) begin
      st_next = ST_DETECTING;
    end else if (drop) begin
      st_next = ST_SEARCHING;
    end else begin
      st_next = cur.state;
    end
  end

  // Update for a tick or a signal word
  always_comb begin
    nxt      = cur;
    low_nxt  = low_cnt;
    det_nxt  = det_cnt;
    cool_nxt = cool_cnt;
    if (kind == ITEM_TICK) begin
      if (low_cnt != '1) low_nxt = low_cnt + COUNT_BITS'(1);
      if (cur.state == ST_DETECTING) begin
        if (det_cnt != '1) det_nxt = det_cnt + COUNT_BITS'(1);
      end else begin
        det_nxt = '0;
      end
      if (cooling) cool_nxt = cool_cnt - COUNT_BITS'(1);
    end else begin
      nxt.avg = avg_new;
      low_nxt = low_sig;
      if (hit) begin
        nxt.x    = half_avg(cur.x, clamp_center(center_x));
        nxt.y    = half_avg(cur.y, clamp_center(center_y));
        nxt.fill = half_avg(cur.fill, fill);
      end
      if (st_next == ST_DETECTED) begin
        nxt.reached_red = 1'b1;
        cool_nxt        = '0;
      end
      if ((cur.state == ST_SEARCHING) && (st_next == ST_DETECTING)) nxt.reached_red = 1'b0;
      if ((cur.state != ST_SEARCHING) && (st_next == ST_SEARCHING) && !cur.reached_red) begin
        cool_nxt = cd_load;
      end
      nxt.state = st_next;
    end
  end

endmodule
